// File: src/xor_fec_packet_recovery_top_assert.svh
// assertion macros for the xor fec packet recovery block
`ifndef XOR_FEC_PACKET_RECOVERY_TOP_ASSERT_SVH
`define XOR_FEC_PACKET_RECOVERY_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define XFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define XFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/xfec_pkg.sv
// package with constants and state type of the xor fec packet recovery block
package xfec_pkg;

  localparam int PAYLOAD_BYTES_DEF = 160;
  localparam int SEQ_BITS_DEF      = 16;
  localparam int CNT_W             = 12;
  localparam int CNT_MAX           = 4095;
  localparam int EXT_HALF          = 128;
  localparam int EXT_STEP          = 256;
  localparam int FWD_LIMIT         = 30000;
  localparam logic [15:0] RW_RESET = 16'd100;

  typedef enum logic [12:0] {
    ST_CLR  = 13'b0000000000001,
    ST_IDLE = 13'b0000000000010,
    ST_CSEQ = 13'b0000000000100,
    ST_CMAP = 13'b0000000001000,
    ST_COPY = 13'b0000000010000,
    ST_POST = 13'b0000000100000,
    ST_SCHK = 13'b0000001000000,
    ST_SP0  = 13'b0000010000000,
    ST_SP1  = 13'b0000100000000,
    ST_SP2  = 13'b0001000000000,
    ST_REB  = 13'b0010000000000,
    ST_DRD  = 13'b0100000000000,
    ST_EMIT = 13'b1000000000000
  } state_t;

endpackage

// File: src/xor_fec_packet_recovery_top.sv
// a datagram byte or an idle drain goes from IDLE to EMIT; a drain with data reads in DRD first
// datagram end: CSEQ, CMAP, COPY and POST store it; a second COPY pass keeps the parity
// recovery search: SCHK and SP0 for each scanned sequence, SP1 and SP2 with parity, REB per rebuild
// throughput: one item at a time
// reset: a clearing pass over all 2**SEQ_BITS map entries (65536 by default)
// clears the map; no item is accepted meanwhile, configuration writes are
`include "xor_fec_packet_recovery_top_assert.svh"
module xor_fec_packet_recovery_top
  import xfec_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int SEQ_BITS      = SEQ_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,   // recovery_window
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // cmd
  input  logic        in_tlast,   // end_of_datagram
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_seq, out_byte, busy_res, dropped, zero pad
  output logic        out_tuser,  // out_valid
  output logic        out_tlast   // packet_end
);

  localparam int SB    = SEQ_BITS;
  localparam int P     = PAYLOAD_BYTES;
  localparam int IW    = (P > 1) ? $clog2(P) : 1;
  localparam int CW    = $clog2(P + 1);
  localparam int STAGE = 2 * P + 1;
  localparam int SAW   = $clog2(STAGE);
  localparam int AW    = SB + IW;

  logic [1:0] map_mem [2**SB];
  logic [7:0] pay_mem [2**AW];
  logic [7:0] par_mem [2**AW];
  logic [7:0] stg_mem [STAGE];

  state_t          state_r;
  logic [SB-1:0]   clr_r;
  logic [15:0]     rw_r;
  logic [CNT_W-1:0] bcnt_r;
  logic [SB-1:0]   latest_r;
  logic [SB:0]     scan_r;
  logic            progress_r;
  logic [SB-1:0]   play_seq_r;
  logic [IW-1:0]   play_idx_r;
  logic            active_r;
  logic            full_r, fresh_r, take_r, cp_par_r;
  logic [CW-1:0]   cnt_r;
  logic [SB-1:0]   s_r, i_r, dst_r, src_r;
  logic [1:0]      e1_r;
  logic            res_valid_r, res_pend_r, res_drop_r;
  logic [SB-1:0]   res_seq_r;
  logic [7:0]      res_byte_r;
  logic            out_v_r, out_user_r, out_last_r;
  logic [31:0]     out_data_r;

  logic [1:0]      map_rd;
  logic [7:0]      pay_rd, par_rd, stg_rd;
  logic            map_we, pay_we, par_we, stg_we;
  logic [SB-1:0]   map_raddr, map_waddr;
  logic [1:0]      map_wdata;
  logic [AW-1:0]   pay_raddr, pay_waddr, par_raddr, par_waddr;
  logic [7:0]      pay_wdata;
  logic [SAW-1:0]  stg_raddr;
  logic            in_acc;
  logic [CNT_W-1:0] cnt_inc;
  logic [IW-1:0]   widx;
  logic [17:0]     ss_w2, ss_l, ss_diff;
  logic [SB:0]     scan_start_c;
  logic [SB-1:0]   s0, s1;
  logic            upd_c;
  logic [SB-1:0]   i_m1, i_m2;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE) && (!out_v_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign cnt_inc = (bcnt_r < CNT_W'(CNT_MAX)) ? bcnt_r + 1'b1 : bcnt_r;
  assign widx    = IW'(cnt_r - 1'b1);
  assign i_m1    = i_r - 1'b1;
  assign i_m2    = i_r - SB'(2);

  // scan start against the latest sequence
  always_comb begin
    ss_l    = 18'(latest_r);
    ss_w2   = 18'(rw_r) + 18'd2;
    ss_diff = ss_l - 18'(rw_r);
    scan_start_c = (ss_l >= ss_w2) ? ss_diff[SB:0] : (SB+1)'(2);
  end

  // wire sequence extension
  always_comb begin
    s0 = {latest_r[SB-1:8], stg_rd};
    s1 = s0;
    if (s0 < latest_r && (latest_r - s0) > SB'(EXT_HALF)) begin
      s1 = s0 + SB'(EXT_STEP);
    end else if (s0 > latest_r && (s0 - latest_r) > SB'(EXT_HALF)) begin
      s1 = s0 - SB'(EXT_STEP);
    end
    upd_c = (s1 > latest_r) && (17'(s1 - latest_r) < 17'(FWD_LIMIT));
  end

  // memory ports
  always_comb begin
    map_we    = 1'b0;
    map_waddr = s_r;
    map_wdata = 2'b00;
    map_raddr = '0;
    pay_we    = 1'b0;
    pay_waddr = {s_r, widx};
    pay_wdata = stg_rd;
    pay_raddr = {play_seq_r, play_idx_r};
    par_we    = 1'b0;
    par_waddr = {s_r, widx};
    par_raddr = {i_r, cnt_r[IW-1:0]};
    stg_we    = in_acc && !in_tuser && !active_r && (bcnt_r < CNT_W'(STAGE));
    stg_raddr = '0;
    unique case (state_r)
      ST_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
      end
      ST_CSEQ: map_raddr = s1;
      ST_CMAP: begin
        map_we    = 1'b1;
        map_wdata = {map_rd[1] | (full_r && !map_rd[1]), 1'b1};
      end
      ST_COPY: begin
        if (cp_par_r) begin
          stg_raddr = SAW'(cnt_r) + SAW'(P + 1);
          par_we    = (cnt_r != '0);
        end else begin
          stg_raddr = SAW'(cnt_r) + SAW'(1);
          pay_we    = (cnt_r != '0);
        end
      end
      ST_SCHK: map_raddr = scan_r[SB-1:0];
      ST_SP0:  map_raddr = i_m1;
      ST_SP1:  map_raddr = i_m2;
      ST_SP2: begin
        if (e1_r[0] && !map_rd[0]) begin
          map_we    = 1'b1;
          map_waddr = i_m2;
          map_wdata = {map_rd[1], 1'b1};
        end else if (!e1_r[0] && map_rd[0]) begin
          map_we    = 1'b1;
          map_waddr = i_m1;
          map_wdata = {e1_r[1], 1'b1};
        end
      end
      ST_REB: begin
        pay_raddr = {src_r, cnt_r[IW-1:0]};
        pay_we    = (cnt_r != '0);
        pay_waddr = {dst_r, widx};
        pay_wdata = par_rd ^ pay_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rd <= map_mem[map_raddr];
    if (pay_we) pay_mem[pay_waddr] <= pay_wdata;
    pay_rd <= pay_mem[pay_raddr];
    if (par_we) par_mem[par_waddr] <= stg_rd;
    par_rd <= par_mem[par_raddr];
    if (stg_we) stg_mem[bcnt_r[SAW-1:0]] <= in_tdata;
    stg_rd <= stg_mem[stg_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_r      <= '0;
      rw_r       <= RW_RESET;
      bcnt_r     <= '0;
      latest_r   <= '0;
      scan_r     <= '0;
      progress_r <= 1'b0;
      play_seq_r <= '0;
      play_idx_r <= '0;
      active_r   <= 1'b0;
      cnt_r      <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_valid) rw_r <= cfg_data;
      if (state_r == ST_EMIT) begin
        out_v_r    <= 1'b1;
        out_user_r <= res_valid_r;
        out_last_r <= res_pend_r;
        out_data_r <= {6'd0, res_drop_r, active_r, res_byte_r, 16'(res_seq_r)};
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            res_valid_r <= 1'b0;
            res_pend_r  <= 1'b0;
            res_drop_r  <= 1'b0;
            res_seq_r   <= '0;
            res_byte_r  <= '0;
            if (in_tuser) begin
              state_r <= active_r ? ST_DRD : ST_EMIT;
            end else if (active_r) begin
              res_drop_r <= 1'b1;
              state_r    <= ST_EMIT;
            end else if (in_tlast) begin
              bcnt_r  <= '0;
              full_r  <= (cnt_inc == CNT_W'(STAGE));
              state_r <= (cnt_inc < CNT_W'(P + 1)) ? ST_EMIT : ST_CSEQ;
            end else begin
              bcnt_r  <= cnt_inc;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_CSEQ: begin
          s_r <= s1;
          if (upd_c) latest_r <= s1;
          state_r <= ST_CMAP;
        end
        ST_CMAP: begin
          fresh_r  <= !map_rd[0];
          take_r   <= full_r && !map_rd[1];
          cp_par_r <= map_rd[0];
          cnt_r    <= '0;
          state_r  <= (!map_rd[0] || (full_r && !map_rd[1])) ? ST_COPY : ST_POST;
        end
        ST_COPY: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(P)) begin
            if (!cp_par_r && take_r) begin
              cp_par_r <= 1'b1;
              cnt_r    <= '0;
            end else begin
              state_r <= ST_POST;
            end
          end
        end
        ST_POST: begin
          scan_r     <= scan_start_c;
          progress_r <= 1'b0;
          if (fresh_r) begin
            play_seq_r <= s_r;
            play_idx_r <= '0;
            active_r   <= 1'b1;
            state_r    <= ST_EMIT;
          end else begin
            state_r <= ST_SCHK;
          end
        end
        ST_SCHK: begin
          if (scan_r > {1'b0, latest_r}) begin
            if (!progress_r) begin
              state_r <= ST_EMIT;
            end else begin
              progress_r <= 1'b0;
              scan_r     <= scan_start_c;
            end
          end else begin
            i_r     <= scan_r[SB-1:0];
            scan_r  <= scan_r + 1'b1;
            state_r <= ST_SP0;
          end
        end
        ST_SP0: state_r <= (i_r < SB'(2) || !map_rd[1]) ? ST_SCHK : ST_SP1;
        ST_SP1: begin
          e1_r    <= map_rd;
          state_r <= ST_SP2;
        end
        ST_SP2: begin
          cnt_r <= '0;
          if (e1_r[0] && !map_rd[0]) begin
            dst_r   <= i_m2;
            src_r   <= i_m1;
            state_r <= ST_REB;
          end else if (!e1_r[0] && map_rd[0]) begin
            dst_r   <= i_m1;
            src_r   <= i_m2;
            state_r <= ST_REB;
          end else begin
            state_r <= ST_SCHK;
          end
        end
        ST_REB: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(P)) begin
            play_seq_r <= dst_r;
            play_idx_r <= '0;
            active_r   <= 1'b1;
            progress_r <= 1'b1;
            state_r    <= ST_EMIT;
          end
        end
        ST_DRD: begin
          res_valid_r <= 1'b1;
          res_seq_r   <= play_seq_r;
          res_byte_r  <= pay_rd;
          if (play_idx_r == IW'(P - 1)) begin
            res_pend_r <= 1'b1;
            active_r   <= 1'b0;
            play_idx_r <= '0;
            state_r    <= ST_SCHK;
          end else begin
            play_idx_r <= play_idx_r + 1'b1;
            state_r    <= ST_EMIT;
          end
        end
        ST_EMIT: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `XFR_ASSERT_NOW(a_in_slot, in_tready, !out_tvalid || out_tready, "beat accepted with output full")
  `XFR_ASSERT_NOW(a_out_src, $rose(out_tvalid), $past(state_r == ST_EMIT), "result beat without emit")
  `XFR_ASSERT_NEXT(a_acc_busy, in_tvalid && in_tready, state_r != ST_IDLE, "accepted beat not taken up")
  `XFR_ASSERT_NOW(a_idx_rng, active_r, play_idx_r < IW'(P) || P == 1, "play index out of range")

endmodule
